// ----- rtl/core/jtpe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package jtpe_pkg;

    localparam int RAW_W    = 8;
    localparam int CFG_W    = 11;
    localparam int POS_W    = 22;
    localparam int IDX_W    = 3;
    localparam int BTN_N    = 3;
    localparam int MUL_STEPS = CFG_W;
    localparam int DIV_STEPS = POS_W;
    localparam int CNT_W    = $clog2(DIV_STEPS + 1);

    localparam logic signed [POS_W+1:0] POS_BIAS = 24'sd38;
    localparam logic signed [POS_W+1:0] POS_MAX  = 24'sd2097151;
    localparam logic signed [POS_W+1:0] POS_MIN  = -24'sd2097152;

    // reciprocal of five for a 9-bit value, exact below 1024
    localparam logic [7:0] RECIP5   = 8'd205;
    localparam int         RECIP5_SH = 10;

    localparam logic [IDX_W-1:0] CFG_X_LOW   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_X_HIGH  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_Y_LOW   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_Y_HIGH  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_SPAN    = 3'd4;
    localparam logic [IDX_W-1:0] CFG_REL     = 3'd5;

    localparam logic EV_MOTION = 1'b0;
    localparam logic EV_BUTTON = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EVAL,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        AX_IDLE,
        AX_MUL,
        AX_DIV,
        AX_FIN
    } t_axis_state;

    typedef struct packed {
        logic                    done;
        logic signed [POS_W-1:0] pos;
    } t_axis_out;

endpackage

`default_nettype wire

// ----- rtl/core/jtpe_axis.sv -----
`timescale 1ns / 1ps
`default_nettype none

module jtpe_axis import jtpe_pkg::*; (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    input  wire signed [RAW_W-1:0]  i_raw,
    input  wire signed [CFG_W-1:0]  i_lo,
    input  wire signed [CFG_W-1:0]  i_hi,
    input  wire        [CFG_W-1:0]  i_span,
    output t_axis_out               o_res
);

    t_axis_state r_state, n_state;

    logic [POS_W-1:0] r_acc, n_acc;
    logic [POS_W-1:0] r_mcand, n_mcand;
    logic [CFG_W-1:0] r_mplier, n_mplier;
    logic [CFG_W-1:0] r_den, n_den;
    logic [CFG_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_neg, n_neg;
    logic             r_zero, n_zero;
    logic             r_done, n_done;
    logic signed [POS_W-1:0] r_pos, n_pos;

    logic signed [CFG_W:0] num, den, num_mag, den_mag;
    logic        [CFG_W:0] rem_sh;
    logic                  ge;
    logic        [POS_W-1:0]   q_mag;
    logic signed [POS_W+1:0]   q_s, sum;

    always_comb begin
        // raw plus 128 is the raw byte with its sign bit flipped
        num     = $signed({4'b0, ~i_raw[RAW_W-1], i_raw[RAW_W-2:0]})
                  - $signed({i_lo[CFG_W-1], i_lo});
        den     = $signed({i_hi[CFG_W-1], i_hi}) - $signed({i_lo[CFG_W-1], i_lo});
        num_mag = num[CFG_W] ? -num : num;
        den_mag = den[CFG_W] ? -den : den;

        rem_sh  = {r_rem, r_acc[POS_W-1]};
        ge      = rem_sh >= {1'b0, r_den};

        q_mag   = r_zero ? '0 : r_acc;
        q_s     = r_neg ? -$signed({2'b0, q_mag}) : $signed({2'b0, q_mag});
        sum     = q_s - $signed({{(POS_W+3-CFG_W){1'b0}}, i_span[CFG_W-1:1]}) + POS_BIAS;

        n_state  = r_state;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_den    = r_den;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_neg    = r_neg;
        n_zero   = r_zero;
        n_done   = 1'b0;
        n_pos    = r_pos;

        case (r_state)
            AX_IDLE: begin
                if (i_start) begin
                    n_neg    = num[CFG_W] ^ den[CFG_W];
                    n_zero   = (den == '0);
                    n_den    = den_mag[CFG_W-1:0];
                    n_mcand  = {{(POS_W-CFG_W){1'b0}}, num_mag[CFG_W-1:0]};
                    n_mplier = i_span;
                    n_acc    = '0;
                    n_rem    = '0;
                    n_cnt    = '0;
                    n_state  = AX_MUL;
                end
            end
            AX_MUL: begin
                if (r_mplier[0]) begin
                    n_acc = r_acc + r_mcand;
                end
                n_mcand  = {r_mcand[POS_W-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[CFG_W-1:1]};
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = AX_DIV;
                end
            end
            AX_DIV: begin
                n_rem = ge ? CFG_W'(rem_sh - {1'b0, r_den}) : rem_sh[CFG_W-1:0];
                n_acc = {r_acc[POS_W-2:0], ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = AX_FIN;
                end
            end
            AX_FIN: begin
                if (sum > POS_MAX) begin
                    n_pos = POS_MAX[POS_W-1:0];
                end else if (sum < POS_MIN) begin
                    n_pos = POS_MIN[POS_W-1:0];
                end else begin
                    n_pos = sum[POS_W-1:0];
                end
                n_done  = 1'b1;
                n_state = AX_IDLE;
            end
            default: begin
                n_state = AX_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= AX_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_den    <= n_den;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_neg    <= n_neg;
        r_zero   <= n_zero;
        r_pos    <= n_pos;
    end

    assign o_res = {r_done, r_pos};

endmodule

`default_nettype wire

// ----- rtl/core/joystick_to_pointer_events_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                 payload
// in        sink       i_in_valid / o_in_ready   i_stick_x, i_stick_y, i_button_bits
// out       source     o_out_valid / i_out_ready o_event_kind .. o_last_of_run
// cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// a sample runs these steps from acceptance until its first event is valid: each
// axis runs an 11-step shift-add multiply and a 22-step restoring divide, one bit
// a cycle, both axes side by side; each axis then saturates its result, and the
// unit captures both, evaluates them and loads the first event
// up to four events follow, one per cycle while o_out_valid is taken
// synchronous active-low reset restores the register defaults and clears history
// the next sample is taken once the last event is in the output register

module joystick_to_pointer_events_unit import jtpe_pkg::*; (
    input  wire                     i_clk,
    input  wire                     i_rst_n,

    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  wire signed [RAW_W-1:0]  i_stick_x,
    input  wire signed [RAW_W-1:0]  i_stick_y,
    input  wire        [RAW_W-1:0]  i_button_bits,

    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output logic                    o_event_kind,
    output logic signed [POS_W-1:0] o_move_x,
    output logic signed [POS_W-1:0] o_move_y,
    output logic [1:0]              o_button_number,
    output logic                    o_button_pressed,
    output logic                    o_last_of_run,

    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire [IDX_W-1:0]         i_cfg_index,
    input  wire [CFG_W-1:0]         i_cfg_data
);

    t_state r_state, n_state;

    logic signed [CFG_W-1:0] r_x_low, r_x_high, r_y_low, r_y_high;
    logic        [CFG_W-1:0] r_span;
    logic                    r_rel;

    logic signed [POS_W-1:0] r_prev_x, n_prev_x, r_prev_y, n_prev_y;
    logic [BTN_N-1:0]        r_prev_btn, n_prev_btn;
    logic [BTN_N-1:0]        r_btn, n_btn;
    logic signed [POS_W-1:0] r_px, n_px, r_py, n_py;
    logic signed [POS_W-1:0] r_mx, n_mx, r_my, n_my;
    logic [BTN_N:0]          r_pend, n_pend;

    logic                    r_ov, n_ov;
    logic                    r_kind, n_kind;
    logic signed [POS_W-1:0] r_ox, n_ox, r_oy, n_oy;
    logic [1:0]              r_bn, n_bn;
    logic                    r_bp, n_bp;
    logic                    r_last, n_last;

    t_axis_out ax_x, ax_y;
    logic      start;

    logic signed [POS_W:0]   dx, dy, dzs, pxe, pye;
    logic signed [POS_W-1:0] dx_sat, dy_sat;
    logic [CFG_W+7:0]        dz_prod;
    logic [6:0]              dz;
    logic                    motion;
    logic [BTN_N:0]          sel;
    logic [1:0]              sel_idx;
    logic                    load_ok;

    assign start       = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;

    jtpe_axis u_axis_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_raw   (i_stick_x),
        .i_lo    (r_x_low),
        .i_hi    (r_x_high),
        .i_span  (r_span),
        .o_res   (ax_x)
    );

    jtpe_axis u_axis_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_raw   (i_stick_y),
        .i_lo    (r_y_low),
        .i_hi    (r_y_high),
        .i_span  (r_span),
        .o_res   (ax_y)
    );

    function automatic logic signed [POS_W-1:0] sat(input logic signed [POS_W:0] v);
        logic signed [POS_W+1:0] w;
        w = {v[POS_W], v};
        if (w > POS_MAX) begin
            sat = POS_MAX[POS_W-1:0];
        end else if (w < POS_MIN) begin
            sat = POS_MIN[POS_W-1:0];
        end else begin
            sat = v[POS_W-1:0];
        end
    endfunction

    always_comb begin
        pxe     = {r_px[POS_W-1], r_px};
        pye     = {r_py[POS_W-1], r_py};
        dx      = pxe - $signed({r_prev_x[POS_W-1], r_prev_x});
        dy      = pye - $signed({r_prev_y[POS_W-1], r_prev_y});
        dx_sat  = sat(dx);
        dy_sat  = sat(dy);
        // span / 20 as (span / 4) / 5
        dz_prod = {{(CFG_W-1){1'b0}}, r_span[CFG_W-1:2]} * {{CFG_W{1'b0}}, RECIP5};
        dz      = dz_prod[RECIP5_SH +: 7];
        dzs     = $signed({{(POS_W-6){1'b0}}, dz});
        motion  = r_rel ? ((r_px != r_prev_x) || (r_py != r_prev_y))
                        : ((pxe > dzs) || (pxe < -dzs) || (pye > dzs) || (pye < -dzs));

        if (r_pend[0]) begin
            sel_idx = 2'd0;
        end else if (r_pend[1]) begin
            sel_idx = 2'd1;
        end else if (r_pend[2]) begin
            sel_idx = 2'd2;
        end else begin
            sel_idx = 2'd3;
        end
        sel = (BTN_N+1)'(1) << sel_idx;

        load_ok = !r_ov || i_out_ready;

        n_state    = r_state;
        n_prev_x   = r_prev_x;
        n_prev_y   = r_prev_y;
        n_prev_btn = r_prev_btn;
        n_btn      = r_btn;
        n_px       = r_px;
        n_py       = r_py;
        n_mx       = r_mx;
        n_my       = r_my;
        n_pend     = r_pend;
        n_ov       = r_ov && !i_out_ready;
        n_kind     = r_kind;
        n_ox       = r_ox;
        n_oy       = r_oy;
        n_bn       = r_bn;
        n_bp       = r_bp;
        n_last     = r_last;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_btn   = i_button_bits[BTN_N:1];
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (ax_x.done && ax_y.done) begin
                    n_px    = ax_x.pos;
                    n_py    = ax_y.pos;
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_pend     = {r_btn ^ r_prev_btn, motion};
                n_prev_btn = r_btn;
                if (r_rel) begin
                    n_mx = dx_sat;
                    n_my = dy_sat;
                    if (motion) begin
                        n_prev_x = r_px;
                        n_prev_y = r_py;
                    end
                end else begin
                    n_mx = r_px;
                    n_my = r_py;
                end
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (r_pend == '0) begin
                    n_state = ST_IDLE;
                end else if (load_ok) begin
                    n_ov   = 1'b1;
                    n_last = ((r_pend & ~sel) == '0);
                    n_pend = r_pend & ~sel;
                    if (sel_idx == 2'd0) begin
                        n_kind = EV_MOTION;
                        n_ox   = r_mx;
                        n_oy   = r_my;
                        n_bn   = 2'd0;
                        n_bp   = 1'b0;
                    end else begin
                        n_kind = EV_BUTTON;
                        n_ox   = '0;
                        n_oy   = '0;
                        n_bn   = sel_idx;
                        n_bp   = r_btn[sel_idx - 2'd1];
                    end
                    if ((r_pend & ~sel) == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ov       <= 1'b0;
            r_pend     <= '0;
            r_prev_x   <= '0;
            r_prev_y   <= '0;
            r_prev_btn <= '0;
        end else begin
            r_state    <= n_state;
            r_ov       <= n_ov;
            r_pend     <= n_pend;
            r_prev_x   <= n_prev_x;
            r_prev_y   <= n_prev_y;
            r_prev_btn <= n_prev_btn;
        end
    end

    always_ff @(posedge i_clk) begin
        r_btn  <= n_btn;
        r_px   <= n_px;
        r_py   <= n_py;
        r_mx   <= n_mx;
        r_my   <= n_my;
        r_kind <= n_kind;
        r_ox   <= n_ox;
        r_oy   <= n_oy;
        r_bn   <= n_bn;
        r_bp   <= n_bp;
        r_last <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_low  <= 11'sd0;
            r_x_high <= 11'sd1000;
            r_y_low  <= 11'sd0;
            r_y_high <= 11'sd1000;
            r_span   <= 11'd100;
            r_rel    <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_X_LOW:  r_x_low  <= i_cfg_data;
                CFG_X_HIGH: r_x_high <= i_cfg_data;
                CFG_Y_LOW:  r_y_low  <= i_cfg_data;
                CFG_Y_HIGH: r_y_high <= i_cfg_data;
                CFG_SPAN:   r_span   <= i_cfg_data;
                CFG_REL:    r_rel    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid      = r_ov;
    assign o_event_kind     = r_kind;
    assign o_move_x         = r_ox;
    assign o_move_y         = r_oy;
    assign o_button_number  = r_bn;
    assign o_button_pressed = r_bp;
    assign o_last_of_run    = r_last;

endmodule

`default_nettype wire

// ----- rtl/core/jtpe_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module jtpe_checker import jtpe_pkg::*; (
    input wire                     i_clk,
    input wire                     i_rst_n,
    input wire                     i_in_valid,
    input wire                     o_in_ready,
    input wire                     o_out_valid,
    input wire                     i_out_ready,
    input wire                     o_event_kind,
    input wire signed [POS_W-1:0]  o_move_x,
    input wire signed [POS_W-1:0]  o_move_y,
    input wire [1:0]               o_button_number,
    input wire                     o_button_pressed,
    input wire                     o_last_of_run
);

    // a pending event holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_event_kind)
            && $stable(o_button_number) && $stable(o_last_of_run))
        else $error("output event changed while stalled");

    // button events carry no motion and a real button number
    a_button_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_kind == EV_BUTTON) |->
            (o_move_x == '0) && (o_move_y == '0) && (o_button_number != 2'd0))
        else $error("button event with motion or no button");

    // motion events carry no button
    a_motion_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_kind == EV_MOTION) |->
            (o_button_number == 2'd0) && !o_button_pressed)
        else $error("motion event with button fields");

    // an accepted sample keeps the input side busy while the axes are scaled
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("new request taken during scaling");

endmodule

bind joystick_to_pointer_events_unit jtpe_checker u_jtpe_checker (.*);

`default_nettype wire
